/* hw/rtl/first_fit_bin_allocator_macros.svh */
// assertion macros for the allocator checker
`ifndef FIRST_FIT_BIN_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BIN_ALLOCATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ffba_pkg.sv */
// types, constants and helpers for the first-fit bin allocator
package ffba_pkg;

    localparam int MAX_BINS   = 64;
    localparam int SIZE_BITS  = 16;
    localparam int BIN_BITS   = $clog2(MAX_BINS);
    localparam int NODE_BITS  = BIN_BITS + 1;
    localparam int TREE_SIZE  = 2 * MAX_BINS;
    localparam int COUNT_BITS = 7;

    localparam logic [SIZE_BITS-1:0]  CAP_RESET  = SIZE_BITS'(1000);
    localparam logic [COUNT_BITS-1:0] BINS_RESET = COUNT_BITS'(MAX_BINS);

    localparam logic [NODE_BITS-1:0] ROOT_NODE = NODE_BITS'(1);
    localparam logic [NODE_BITS-1:0] LAST_NODE = NODE_BITS'(TREE_SIZE - 1);

    // request codes
    localparam logic [1:0] REQ_PLACE   = 2'd0;
    localparam logic [1:0] REQ_RESTART = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;
    localparam logic [1:0] REQ_RSVD    = 2'd3;

    // status codes
    localparam logic [1:0] ST_PLACED    = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_RESTARTED = 2'd2;
    localparam logic [1:0] ST_READ_DONE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_BIN_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_BINS_USED    = 2'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] obj_size;
        logic [5:0]  read_bin;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  bin_number;
        logic [15:0] room_left;
    } out_t;

    // one tree entry: the winning bin below a node and that bin's room
    typedef struct packed {
        logic                 active;
        logic [BIN_BITS-1:0]  idx;
        logic [SIZE_BITS-1:0] room;
    } node_t;

    // leftmost leaf below a node; the winner of any node of a freshly filled tree
    function automatic logic [BIN_BITS-1:0] leftmost_leaf(input logic [NODE_BITS-1:0] node);
        logic [BIN_BITS-1:0]  lo;
        logic [NODE_BITS-1:0] sh;
        lo = '0;
        for (int k = 0; k < NODE_BITS; k++)
        begin
            sh = node << (NODE_BITS - 1 - k);
            if (node[k])
            begin
                lo = sh[BIN_BITS-1:0];
            end
        end
        return lo;
    endfunction

    // active bins outrank inactive ones, then more room wins
    function automatic logic key_ge(input node_t a, input node_t b);
        return {a.active, a.room} >= {b.active, b.room};
    endfunction

endpackage

/* hw/rtl/first_fit_bin_allocator.sv */
// first-fit bin allocator: winner tree of bin room kept in one ram
// place: root, 6 descent reads, leaf, 6 replays from accept to result; no fit stops after the root
// restart: one tree entry written per cycle over all 128 entries
// read: one item at a time, every step bound by the single ram read port
// after reset a fill builds the tree for 64 bins of room 1000, no item taken
// meanwhile; configuration writes are taken at any time and apply at the next restart
module first_fit_bin_allocator
    import ffba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_t        in_data,
    input  logic       in_valid,
    output logic       in_stall,
    output out_t       out_data,
    output logic       out_valid,
    input  logic       out_stall,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_DESC  = 3'd3;
    localparam logic [2:0] S_LEAF  = 3'd4;
    localparam logic [2:0] S_UP    = 3'd5;
    localparam logic [2:0] S_READ  = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [NODE_BITS-1:0]  node_reg, node_next;
    node_t                 cur_reg, cur_next;
    logic [SIZE_BITS-1:0]  size_reg, size_next;
    out_t                  res_reg, res_next;
    logic                  restart_pend_reg, restart_pend_next;
    logic [NODE_BITS-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic [SIZE_BITS-1:0]  sweep_cap_reg, sweep_cap_next;
    logic [COUNT_BITS-1:0] sweep_n_reg, sweep_n_next;
    logic [SIZE_BITS-1:0]  cap_cfg_reg, cap_cfg_next;
    logic [COUNT_BITS-1:0] bins_cfg_reg, bins_cfg_next;
    out_t                  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  ram_we;
    logic [NODE_BITS-1:0]  ram_waddr;
    node_t                 ram_wdata;
    logic [NODE_BITS-1:0]  ram_raddr;
    logic [$bits(node_t)-1:0] ram_rdata;
    node_t                 rd_node;

    ffba_ram #(
        .WIDTH($bits(node_t)),
        .DEPTH(TREE_SIZE)
    ) u_tree_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_node   = ram_rdata;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        logic                  out_take;
        logic                  fits;
        logic [BIN_BITS-1:0]   lo;
        logic                  lo_active;
        logic [NODE_BITS-1:0]  child;
        logic [NODE_BITS-1:0]  parent;
        logic [SIZE_BITS-1:0]  new_room;
        node_t                 leaf_node;
        node_t                 win;
        logic [COUNT_BITS-1:0] n_clamped;

        state_next        = state_reg;
        node_next         = node_reg;
        cur_next          = cur_reg;
        size_next         = size_reg;
        res_next          = res_reg;
        restart_pend_next = restart_pend_reg;
        sweep_cnt_next    = sweep_cnt_reg;
        sweep_cap_next    = sweep_cap_reg;
        sweep_n_next      = sweep_n_reg;
        cap_cfg_next      = cap_cfg_reg;
        bins_cfg_next     = bins_cfg_reg;
        out_next          = out_reg;

        out_take       = out_valid_reg && !out_stall;
        out_valid_next = out_valid_reg && !out_take;

        ram_we    = 1'b0;
        ram_waddr = node_reg;
        ram_wdata = cur_reg;
        ram_raddr = node_reg;

        fits      = rd_node.active && (rd_node.room >= size_reg);
        child     = {node_reg[NODE_BITS-2:0], 1'b0};
        parent    = node_reg >> 1;
        new_room  = rd_node.room - size_reg;
        leaf_node = '{active: rd_node.active, idx: rd_node.idx, room: new_room};

        // path entry against its sibling, ties to the lower index
        if (!node_reg[0])
        begin
            win = key_ge(cur_reg, rd_node) ? cur_reg : rd_node;
        end
        else
        begin
            win = key_ge(rd_node, cur_reg) ? rd_node : cur_reg;
        end

        lo        = leftmost_leaf(sweep_cnt_reg);
        lo_active = {1'b0, lo} < sweep_n_reg;

        if (bins_cfg_reg == '0)
        begin
            n_clamped = COUNT_BITS'(1);
        end
        else if (bins_cfg_reg > COUNT_BITS'(MAX_BINS))
        begin
            n_clamped = COUNT_BITS'(MAX_BINS);
        end
        else
        begin
            n_clamped = bins_cfg_reg;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BIN_CAPACITY: cap_cfg_next = cfg_data;
                CFG_BINS_USED:    bins_cfg_next = cfg_data[COUNT_BITS-1:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            S_SWEEP:
            begin
                ram_we         = 1'b1;
                ram_waddr      = sweep_cnt_reg;
                ram_wdata      = '{active: lo_active, idx: lo,
                                   room: lo_active ? sweep_cap_reg : '0};
                sweep_cnt_next = sweep_cnt_reg + NODE_BITS'(1);
                if (sweep_cnt_reg == LAST_NODE)
                begin
                    if (restart_pend_reg)
                    begin
                        res_next   = '{status: ST_RESTARTED, bin_number: '0,
                                       room_left: sweep_cap_reg};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                    restart_pend_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_data.req_type)
                        REQ_PLACE:
                        begin
                            size_next  = in_data.obj_size;
                            ram_raddr  = ROOT_NODE;
                            state_next = S_ROOT;
                        end
                        REQ_RESTART:
                        begin
                            sweep_cnt_next    = '0;
                            sweep_cap_next    = cap_cfg_reg;
                            sweep_n_next      = n_clamped;
                            restart_pend_next = 1'b1;
                            state_next        = S_SWEEP;
                        end
                        default:
                        begin
                            // read and the spare code both read a leaf
                            ram_raddr  = {1'b1, in_data.read_bin};
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_ROOT:
            begin
                if (fits)
                begin
                    node_next  = ROOT_NODE;
                    ram_raddr  = {ROOT_NODE[NODE_BITS-2:0], 1'b0};
                    state_next = S_DESC;
                end
                else
                begin
                    res_next   = '{status: ST_NO_FIT, bin_number: '0, room_left: '0};
                    state_next = S_EMIT;
                end
            end
            S_DESC:
            begin
                // rd_node is the left child; step right when it cannot take the object
                if (!fits)
                begin
                    child = child | NODE_BITS'(1);
                end
                node_next = child;
                if (node_reg[NODE_BITS-2])
                begin
                    // child is a leaf: fetch it for the update
                    ram_raddr  = child;
                    state_next = S_LEAF;
                end
                else
                begin
                    ram_raddr = {child[NODE_BITS-2:0], 1'b0};
                end
            end
            S_LEAF:
            begin
                cur_next   = leaf_node;
                ram_we     = 1'b1;
                ram_waddr  = node_reg;
                ram_wdata  = leaf_node;
                res_next   = '{status: ST_PLACED, bin_number: rd_node.idx,
                               room_left: new_room};
                ram_raddr  = node_reg ^ NODE_BITS'(1);
                state_next = S_UP;
            end
            S_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = win;
                cur_next  = win;
                node_next = parent;
                ram_raddr = parent ^ NODE_BITS'(1);
                if (parent == ROOT_NODE)
                begin
                    state_next = S_EMIT;
                end
            end
            S_READ:
            begin
                res_next   = '{status: ST_READ_DONE, bin_number: rd_node.idx,
                               room_left: rd_node.room};
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_SWEEP;
            restart_pend_reg <= 1'b0;
            sweep_cnt_reg    <= '0;
            sweep_cap_reg    <= CAP_RESET;
            sweep_n_reg      <= BINS_RESET;
            cap_cfg_reg      <= CAP_RESET;
            bins_cfg_reg     <= BINS_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            restart_pend_reg <= restart_pend_next;
            sweep_cnt_reg    <= sweep_cnt_next;
            sweep_cap_reg    <= sweep_cap_next;
            sweep_n_reg      <= sweep_n_next;
            cap_cfg_reg      <= cap_cfg_next;
            bins_cfg_reg     <= bins_cfg_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        cur_reg  <= cur_next;
        size_reg <= size_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

/* hw/rtl/ffba_ram.sv */
// generic single-write, single-read ram with registered read data
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/ffba_checker.sv */
// port-level checker for the first-fit bin allocator, bound to the top level
`include "first_fit_bin_allocator_macros.svh"

module ffba_checker
    import ffba_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input out_t out_data,
    input logic out_valid,
    input logic out_stall
);

    // a stalled result beat holds
    `FFBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

    // one item at a time: the block is busy right after taking a beat
    `FFBA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken twice in a row")

    // no fit reports bin zero with no room
    `FFBA_ASSERT_NOW(a_no_fit_zero, out_valid && out_data.status == ST_NO_FIT, out_data.bin_number == '0 && out_data.room_left == '0, "no-fit result not zeroed")

    // restart reports bin zero
    `FFBA_ASSERT_NOW(a_restart_bin, out_valid && out_data.status == ST_RESTARTED, out_data.bin_number == '0, "restart result names a bin")

endmodule

bind first_fit_bin_allocator ffba_checker u_ffba_checker (.*);

/* test/first_fit_bin_allocator_tb.sv */
// testbench for the first-fit bin allocator: random and directed requests checked by a scoreboard
`timescale 1ns / 1ps

module first_fit_bin_allocator_tb;
    import ffba_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 500;
    localparam int PHASE_ITEMS = 120;

    // first-fit predictor and queue of expected results
    class alloc_scoreboard;
        logic [15:0] bin_room [MAX_BINS];
        int unsigned live_bins;
        logic [15:0] cap_reg;
        logic [6:0]  bins_reg;
        out_t        expected_q [$];
        int          errors;

        function new();
            cap_reg  = CAP_RESET;
            bins_reg = BINS_RESET;
            errors   = 0;
            refill();
        endfunction

        function void refill();
            int unsigned n;
            n = bins_reg;
            if (n < 1)
            begin
                n = 1;
            end
            if (n > MAX_BINS)
            begin
                n = MAX_BINS;
            end
            live_bins = n;
            for (int i = 0; i < MAX_BINS; i++)
            begin
                bin_room[i] = (i < n) ? cap_reg : 16'd0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] value);
            if (idx == CFG_BIN_CAPACITY)
            begin
                cap_reg = value;
            end
            else if (idx == CFG_BINS_USED)
            begin
                bins_reg = value[6:0];
            end
        endfunction

        function void note_failure(string msg);
            errors++;
            if (errors <= 10)
            begin
                $display("%s", msg);
            end
        endfunction

        function void note_request(in_t req);
            out_t res;
            int   pick;
            pick = -1;
            case (req.req_type)
                REQ_RESTART:
                begin
                    refill();
                    res.status     = ST_RESTARTED;
                    res.bin_number = '0;
                    res.room_left  = cap_reg;
                end
                REQ_PLACE:
                begin
                    // lowest-indexed live bin with enough room
                    for (int b = 0; b < live_bins; b++)
                    begin
                        if (pick < 0 && bin_room[b] >= req.obj_size)
                        begin
                            pick = b;
                        end
                    end
                    if (pick < 0)
                    begin
                        res.status     = ST_NO_FIT;
                        res.bin_number = '0;
                        res.room_left  = '0;
                    end
                    else
                    begin
                        bin_room[pick] = bin_room[pick] - req.obj_size;
                        res.status     = ST_PLACED;
                        res.bin_number = 6'(pick);
                        res.room_left  = bin_room[pick];
                    end
                end
                default:
                begin
                    res.status     = ST_READ_DONE;
                    res.bin_number = req.read_bin;
                    res.room_left  = bin_room[req.read_bin];
                end
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (expected_q.size() == 0)
            begin
                note_failure($sformatf("unexpected result: status %0d bin %0d room %0d",
                                       got.status, got.bin_number, got.room_left));
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.status !== want.status || got.bin_number !== want.bin_number ||
                    got.room_left !== want.room_left)
                begin
                    note_failure($sformatf(
                        "mismatch: expected status %0d bin %0d room %0d, got %0d %0d %0d",
                        want.status, want.bin_number, want.room_left,
                        got.status, got.bin_number, got.room_left));
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    in_t         in_data;
    logic        in_valid;
    logic        in_stall;
    out_t        out_data;
    logic        out_valid;
    logic        out_stall;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    alloc_scoreboard sb = new();

    int burst_left   = 0;
    int quiet_cycles = 0;
    bit hold_request = 1'b0;

    first_fit_bin_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // sample every beat at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                sb.note_request(in_data);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(out_data);
            end
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // result side: stall pattern of its own, plus one long hold
    initial
    begin
        int stall_mode;
        int stall_run;
        bit hold_done;
        stall_mode = 0;
        stall_run  = 0;
        hold_done  = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = 1'b1;
            end
            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_run  = $urandom_range(10, 60);
            end
            stall_run--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 2) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_req(input logic [1:0] kind, input logic [15:0] size,
                            input logic [5:0] bin);
        in_t item;
        item.req_type = kind;
        item.obj_size = size;
        item.read_bin = bin;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned cap;
        int unsigned pick;
        logic [15:0] bins_val;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BIN_CAPACITY;
        cfg_data  = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: 64 bins of 1000
        send_req(REQ_PLACE, 16'd0, 6'($urandom));
        send_req(REQ_PLACE, 16'd1000, 6'($urandom));
        send_req(REQ_PLACE, 16'd0, 6'd63);
        send_req(REQ_PLACE, 16'hFFFF, 6'($urandom));
        send_req(REQ_PLACE, 16'd1001, 6'($urandom));
        send_req(REQ_PLACE, 16'd999, 6'($urandom));
        send_req(REQ_READ, 16'($urandom), 6'd1);
        send_req(REQ_RSVD, 16'($urandom), 6'd63);
        drain();

        // one bin of full capacity
        write_cfg(CFG_BIN_CAPACITY, 16'hFFFF);
        write_cfg(CFG_BINS_USED, 16'd1);
        send_req(REQ_RESTART, 16'($urandom), 6'($urandom));
        send_req(REQ_PLACE, 16'hFFFF, 6'($urandom));
        send_req(REQ_PLACE, 16'd1, 6'($urandom));
        send_req(REQ_PLACE, 16'd0, 6'($urandom));
        send_req(REQ_READ, 16'($urandom), 6'd1);
        drain();

        // bin count above the maximum clamps down
        write_cfg(CFG_BIN_CAPACITY, 16'd1);
        write_cfg(CFG_BINS_USED, 16'd127);
        send_req(REQ_RESTART, 16'($urandom), 6'($urandom));
        send_req(REQ_PLACE, 16'd1, 6'($urandom));
        send_req(REQ_PLACE, 16'd1, 6'($urandom));
        send_req(REQ_RSVD, 16'($urandom), 6'd63);
        drain();

        // bin count of zero clamps up to one, upper data bits dropped
        write_cfg(CFG_BIN_CAPACITY, 16'd255);
        write_cfg(CFG_BINS_USED, 16'hFF80);
        send_req(REQ_RESTART, 16'($urandom), 6'($urandom));
        send_req(REQ_PLACE, 16'd200, 6'($urandom));
        send_req(REQ_PLACE, 16'd100, 6'($urandom));
        send_req(REQ_READ, 16'($urandom), 6'd0);
        send_req(REQ_READ, 16'($urandom), 6'd5);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       cap = 1;
                1:       cap = 65535;
                2:       cap = $urandom_range(20, 3000);
                default: cap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 65535)
                                                             : $urandom_range(2, 500);
            endcase
            case (phase)
                0:       bins_val = 16'd64;
                1:       bins_val = 16'd3;
                3:       bins_val = 16'($urandom_range(65, 127));
                default: bins_val = 16'($urandom_range(1, 64));
            endcase
            write_cfg(CFG_BIN_CAPACITY, 16'(cap));
            write_cfg(CFG_BINS_USED, bins_val);
            send_req(REQ_RESTART, 16'($urandom), 6'($urandom));
            if (phase == 2)
            begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    send_req(REQ_PLACE, 16'($urandom_range(0, cap / 3 + 1)), 6'($urandom));
                end
                else if (pick < 70)
                begin
                    send_req(REQ_PLACE, 16'($urandom_range(0, cap)), 6'($urandom));
                end
                else if (pick < 85)
                begin
                    send_req(($urandom_range(0, 1) == 0) ? REQ_READ : REQ_RSVD,
                             16'($urandom), 6'($urandom));
                end
                else if (pick < 88)
                begin
                    send_req(REQ_RESTART, 16'($urandom), 6'($urandom));
                end
                else
                begin
                    send_req(REQ_PLACE, 16'($urandom), 6'($urandom));
                end
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.note_failure($sformatf("%0d results never arrived", sb.pending()));
        end
        if (sb.errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
